// ===== design/lcdw_pkg.sv =====
// ----------------------------------------------------------------------------
// lcdw_pkg
// Shared constants, types and the digit pattern table of the segment LCD
// digit writer.
// ----------------------------------------------------------------------------
`default_nettype none

package lcdw_pkg;

  // Digit positions and shadow geometry
  localparam int POSITIONS    = 6;
  localparam int POS_W        = 3;
  localparam int PPOS_W       = POS_W + 1;
  localparam int ROWS         = 4;
  localparam int ROW_W        = $clog2(ROWS);
  localparam int ROW_STRIDE   = 5;
  localparam int SHADOW_DEPTH = 15 + (POSITIONS + 1) / 2;
  localparam int IDX_W        = 5;
  localparam int DATA_W       = 8;
  localparam int NIB_W        = 4;
  localparam int PAT_W        = ROWS * NIB_W;

  localparam logic [DATA_W-1:0] KEEP_BITS = 8'h66;
  localparam logic [DATA_W-1:0] MASK_LO   = 8'h0F;
  localparam logic [DATA_W-1:0] MASK_HI   = 8'hF0;

  // Digit codes
  localparam int SEL_W = 4;
  localparam logic [SEL_W-1:0] BLANK_CODE = 4'd10;
  localparam logic [7:0]       CHAR_ZERO  = 8'h30;
  localparam logic [7:0]       DIGIT_MAX  = 8'd9;

  // Decimal digit split by reciprocal multiplication
  localparam int NUM_W      = 31;
  localparam int REM_W      = 7;
  localparam int PROD_W     = 2 * NUM_W;
  localparam int HUND_SHIFT = 37;
  localparam int QUO_W      = PROD_W - HUND_SHIFT;
  localparam int TEN_SHIFT  = 11;
  localparam int TEN_PROD_W = TEN_SHIFT + SEL_W;
  localparam logic [NUM_W-1:0] RECIP_HUND = 31'h51EB_851F;
  localparam logic [7:0]       RECIP_TEN  = 8'd205;
  localparam logic [REM_W-1:0] DIV_HUND   = 7'd100;
  localparam logic [SEL_W-1:0] DIV_TEN    = 4'd10;

  typedef struct packed {
    logic             start;
    logic             two;
    logic [POS_W-1:0] pos;
    logic [SEL_W-1:0] sel0;
    logic [SEL_W-1:0] sel1;
  } lcdw_job_t;

  typedef struct packed {
    logic             done;
    logic [SEL_W-1:0] tens;
    logic [SEL_W-1:0] units;
  } lcdw_div_res_t;

  function automatic logic [PAT_W-1:0] digit_pattern(input logic [SEL_W-1:0] sel);
    logic [PAT_W-1:0] pat;
    case (sel)
      4'd0:    pat = 16'h1551;
      4'd1:    pat = 16'h2080;
      4'd2:    pat = 16'h1e11;
      4'd3:    pat = 16'h1b11;
      4'd4:    pat = 16'h0b50;
      4'd5:    pat = 16'h1b41;
      4'd6:    pat = 16'h1f41;
      4'd7:    pat = 16'h0111;
      4'd8:    pat = 16'h1f51;
      4'd9:    pat = 16'h1b51;
      default: pat = 16'h0000;
    endcase
    return pat;
  endfunction

endpackage

`default_nettype wire

// ===== design/lcd_digit_segment_writer.sv =====
// ----------------------------------------------------------------------------
// lcd_digit_segment_writer
// Turns character or two-digit number requests into segment LCD register
// writes, keeping a shadow of the data registers.
// ----------------------------------------------------------------------------
// Usage: the input channel (in_valid/in_stall) carries one request: a
// character at a position (in_req_type 0) or the tens and units digits of
// in_number at position and position+1 (in_req_type 1). The output channel
// (out_valid/out_stall) carries one word per register write: index, new byte
// and out_last on the final word of the request. Positions 6 and 7 write
// nothing; a number at position 5 writes only its tens digit.
// Timing: one request at a time; in_stall stays high until all row writes
// are issued. A character goes through job hand-off, four row writes at one
// per cycle while the receiver does not stall a held word, and wrap-up. A
// number first passes the reciprocal-multiply digit split and writes up to
// eight rows, or four when only the tens digit is written. A stall of a
// held word pauses the sequencer.
// Reset (rst_n low, synchronous) clears the shadow and drops all valids.
// ----------------------------------------------------------------------------
`default_nettype none

module lcd_digit_segment_writer (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        in_valid,
  output logic                             in_stall,
  input  wire logic                        in_req_type,
  input  wire logic [7:0]                  in_char_code,
  input  wire logic [lcdw_pkg::NUM_W-1:0]  in_number,
  input  wire logic [lcdw_pkg::POS_W-1:0]  in_position,
  output logic                             out_valid,
  input  wire logic                        out_stall,
  output logic [lcdw_pkg::IDX_W-1:0]       out_reg_index,
  output logic [lcdw_pkg::DATA_W-1:0]      out_reg_data,
  output logic                             out_last
);

  typedef enum logic [1:0] {S_IDLE, S_DIV, S_JOB, S_WAIT} state_t;

  state_t                         state_r;
  state_t                         state_nxt;
  logic                           two_r;
  logic [lcdw_pkg::POS_W-1:0]     pos_r;
  logic [lcdw_pkg::SEL_W-1:0]     sel0_r;
  logic [lcdw_pkg::SEL_W-1:0]     sel1_r;

  logic                           accept;
  logic [7:0]                     char_off;
  logic [lcdw_pkg::SEL_W-1:0]     char_sel;
  logic                           seg_busy;
  lcdw_pkg::lcdw_div_res_t        div_res;
  lcdw_pkg::lcdw_job_t            job;

  assign accept   = in_valid && !in_stall;
  assign in_stall = (state_r != S_IDLE);

  // characters below '0' wrap and fail the digit test
  assign char_off = in_char_code - lcdw_pkg::CHAR_ZERO;
  assign char_sel = (char_off > lcdw_pkg::DIGIT_MAX) ? lcdw_pkg::BLANK_CODE
                                                     : char_off[lcdw_pkg::SEL_W-1:0];

  lcdw_div u_div (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (accept && in_req_type),
    .number (in_number),
    .res    (div_res)
  );

  assign job.start = (state_r == S_JOB);
  assign job.two   = two_r;
  assign job.pos   = pos_r;
  assign job.sel0  = sel0_r;
  assign job.sel1  = sel1_r;

  lcdw_seg u_seg (
    .clk           (clk),
    .rst_n         (rst_n),
    .job           (job),
    .busy          (seg_busy),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_reg_index (out_reg_index),
    .out_reg_data  (out_reg_data),
    .out_last      (out_last)
  );

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE:  if (accept) state_nxt = in_req_type ? S_DIV : S_JOB;
      S_DIV:   if (div_res.done) state_nxt = S_JOB;
      S_JOB:   state_nxt = S_WAIT;
      S_WAIT:  if (!seg_busy) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
      if (accept) begin
        two_r  <= in_req_type;
        pos_r  <= in_position;
        sel0_r <= char_sel;
      end
      if (state_r == S_DIV && div_res.done) begin
        sel0_r <= div_res.tens;
        sel1_r <= div_res.units;
      end
    end
  end

`ifndef NO_ASSERTIONS
  a_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
    div_res.done |-> state_r == S_DIV)
    else $error("divider result outside divide phase");

  a_idle_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_IDLE |-> !seg_busy)
    else $error("new request taken while row writes pending");

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> state_r == S_DIV || state_r == S_JOB)
    else $error("accepted request did not start");
`endif

endmodule

`default_nettype wire

// ===== design/lcdw_div.sv =====
// ----------------------------------------------------------------------------
// lcdw_div
// Decimal digit split: takes the number modulo 100 by a reciprocal multiply,
// then splits the remainder into tens and units, one step per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module lcdw_div (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       start,
  input  wire logic [lcdw_pkg::NUM_W-1:0] number,
  output lcdw_pkg::lcdw_div_res_t         res
);

  typedef enum logic [1:0] {D_IDLE, D_QUO, D_REM, D_DIG} phase_t;

  phase_t                           phase_r;
  logic [lcdw_pkg::NUM_W-1:0]       num_r;
  logic [lcdw_pkg::QUO_W-1:0]       quo_r;
  logic [lcdw_pkg::REM_W-1:0]       rem_r;
  logic                             done_r;
  logic [lcdw_pkg::SEL_W-1:0]       tens_r;
  logic [lcdw_pkg::SEL_W-1:0]       units_r;

  logic [lcdw_pkg::PROD_W-1:0]      hund_prod;
  logic [lcdw_pkg::REM_W-1:0]       quo_x100;
  logic [lcdw_pkg::REM_W-1:0]       rem_nxt;
  logic [lcdw_pkg::TEN_PROD_W-1:0]  ten_prod;
  logic [lcdw_pkg::SEL_W-1:0]       tens_nxt;
  logic [lcdw_pkg::SEL_W-1:0]       units_nxt;

  always_comb begin
    hund_prod = lcdw_pkg::PROD_W'(num_r) * lcdw_pkg::PROD_W'(lcdw_pkg::RECIP_HUND);
    // remainder fits in 7 bits, so the low bits of the product suffice
    quo_x100  = lcdw_pkg::REM_W'(quo_r[lcdw_pkg::REM_W-1:0] * lcdw_pkg::DIV_HUND);
    rem_nxt   = num_r[lcdw_pkg::REM_W-1:0] - quo_x100;
    ten_prod  = lcdw_pkg::TEN_PROD_W'(rem_r) * lcdw_pkg::TEN_PROD_W'(lcdw_pkg::RECIP_TEN);
    tens_nxt  = ten_prod[lcdw_pkg::TEN_PROD_W-1:lcdw_pkg::TEN_SHIFT];
    units_nxt = rem_r[lcdw_pkg::SEL_W-1:0]
              - lcdw_pkg::SEL_W'(tens_nxt * lcdw_pkg::DIV_TEN);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= D_IDLE;
      done_r  <= 1'b0;
    end else begin
      case (phase_r)
        D_IDLE: begin
          done_r <= 1'b0;
          if (start) begin
            num_r   <= number;
            phase_r <= D_QUO;
          end
        end
        D_QUO: begin
          quo_r   <= hund_prod[lcdw_pkg::PROD_W-1:lcdw_pkg::HUND_SHIFT];
          phase_r <= D_REM;
        end
        D_REM: begin
          rem_r   <= rem_nxt;
          phase_r <= D_DIG;
        end
        D_DIG: begin
          tens_r  <= tens_nxt;
          units_r <= units_nxt;
          done_r  <= 1'b1;
          phase_r <= D_IDLE;
        end
        default: phase_r <= D_IDLE;
      endcase
    end
  end

  assign res.done  = done_r;
  assign res.tens  = tens_r;
  assign res.units = units_r;

`ifndef NO_ASSERTIONS
  a_rem_range: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == D_DIG |-> rem_r < lcdw_pkg::DIV_HUND)
    else $error("remainder escaped modulo 100 range");

  a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
    start |-> phase_r == D_IDLE)
    else $error("divider started while busy");

  a_done_src: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> phase_r == D_IDLE && $past(phase_r) == D_DIG)
    else $error("divider done without finishing the digit split");

  a_digits: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> tens_r < lcdw_pkg::DIV_TEN && units_r < lcdw_pkg::DIV_TEN)
    else $error("divider produced a non-decimal digit");
`endif

endmodule

`default_nettype wire

// ===== design/lcdw_seg.sv =====
// ----------------------------------------------------------------------------
// lcdw_seg
// Segment register shadow and row sequencer: one read-modify-write of a
// shadow register per cycle unless a held word is stalled, each emitted as an output word.
// ----------------------------------------------------------------------------
`default_nettype none

module lcdw_seg (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire lcdw_pkg::lcdw_job_t         job,
  output logic                             busy,
  output logic                             out_valid,
  input  wire logic                        out_stall,
  output logic [lcdw_pkg::IDX_W-1:0]       out_reg_index,
  output logic [lcdw_pkg::DATA_W-1:0]      out_reg_data,
  output logic                             out_last
);

  typedef enum logic {W_IDLE, W_RUN} wstate_t;

  wstate_t                          state_r;
  logic [lcdw_pkg::ROW_W-1:0]       row_r;
  logic [lcdw_pkg::PPOS_W-1:0]      pos_r;
  logic [lcdw_pkg::PAT_W-1:0]       pat_r;
  logic [lcdw_pkg::PAT_W-1:0]       pat1_r;
  logic                             second_r;
  logic [lcdw_pkg::DATA_W-1:0]      shadow_r [lcdw_pkg::SHADOW_DEPTH];
  logic                             out_valid_r;
  logic [lcdw_pkg::IDX_W-1:0]       out_idx_r;
  logic [lcdw_pkg::DATA_W-1:0]      out_data_r;
  logic                             out_last_r;

  logic [lcdw_pkg::PPOS_W-1:0]      p0;
  logic [lcdw_pkg::PPOS_W-1:0]      p1;
  logic                             p0_ok;
  logic                             p1_ok;
  logic                             fire;
  logic [lcdw_pkg::IDX_W-1:0]       idx;
  logic [lcdw_pkg::NIB_W-1:0]       nib;
  logic [lcdw_pkg::DATA_W-1:0]      m;
  logic [lcdw_pkg::DATA_W-1:0]      old_byte;
  logic [lcdw_pkg::DATA_W-1:0]      new_byte;

  always_comb begin
    p0    = {1'b0, job.pos};
    p1    = p0 + 1'b1;
    p0_ok = (p0 < lcdw_pkg::PPOS_W'(lcdw_pkg::POSITIONS));
    p1_ok = job.two && (p1 < lcdw_pkg::PPOS_W'(lcdw_pkg::POSITIONS));

    fire = (state_r == W_RUN) && (!out_valid_r || !out_stall);
    idx  = lcdw_pkg::IDX_W'(pos_r[lcdw_pkg::PPOS_W-1:1])
         + lcdw_pkg::IDX_W'(lcdw_pkg::ROW_STRIDE) * lcdw_pkg::IDX_W'(row_r);
    nib  = pat_r[row_r * lcdw_pkg::NIB_W +: lcdw_pkg::NIB_W];
    m    = pos_r[0] ? lcdw_pkg::MASK_HI : lcdw_pkg::MASK_LO;

    old_byte = shadow_r[idx];
    new_byte = (old_byte & ~m) | ({nib, nib} & m);
    // row 0 keeps the bits under the keep mask
    if (row_r == '0) begin
      new_byte = new_byte | (old_byte & lcdw_pkg::KEEP_BITS);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= W_IDLE;
      out_valid_r <= 1'b0;
      row_r       <= '0;
      for (int i = 0; i < lcdw_pkg::SHADOW_DEPTH; i++) begin
        shadow_r[i] <= '0;
      end
    end else begin
      if (out_valid_r && !out_stall && !fire) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        W_IDLE: begin
          // a job with no in-range digit leaves the sequencer idle
          if (job.start && p0_ok) begin
            pos_r    <= p0;
            pat_r    <= lcdw_pkg::digit_pattern(job.sel0);
            pat1_r   <= lcdw_pkg::digit_pattern(job.sel1);
            second_r <= p1_ok;
            row_r    <= '0;
            state_r  <= W_RUN;
          end
        end
        W_RUN: begin
          if (fire) begin
            shadow_r[idx] <= new_byte;
            out_valid_r   <= 1'b1;
            out_idx_r     <= idx;
            out_data_r    <= new_byte;
            out_last_r    <= (row_r == lcdw_pkg::ROW_W'(lcdw_pkg::ROWS - 1)) && !second_r;
            row_r         <= row_r + 1'b1;
            if (row_r == lcdw_pkg::ROW_W'(lcdw_pkg::ROWS - 1)) begin
              if (second_r) begin
                // advance to the units digit
                pos_r    <= pos_r + 1'b1;
                pat_r    <= pat1_r;
                second_r <= 1'b0;
              end else begin
                state_r <= W_IDLE;
              end
            end
          end
        end
        default: state_r <= W_IDLE;
      endcase
    end
  end

  assign busy          = (state_r == W_RUN);
  assign out_valid     = out_valid_r;
  assign out_reg_index = out_idx_r;
  assign out_reg_data  = out_data_r;
  assign out_last      = out_last_r;

`ifndef NO_ASSERTIONS
  a_row_idle: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == W_IDLE |-> row_r == '0)
    else $error("row counter left mid-pattern while idle");

  a_job_idle: assert property (@(posedge clk) disable iff (!rst_n)
    job.start |-> state_r == W_IDLE)
    else $error("job started while sequencer busy");

  a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
    fire |-> idx < lcdw_pkg::IDX_W'(lcdw_pkg::SHADOW_DEPTH))
    else $error("shadow index beyond depth");

  a_last_end: assert property (@(posedge clk) disable iff (!rst_n)
    fire && row_r == lcdw_pkg::ROW_W'(lcdw_pkg::ROWS - 1) && !second_r |=> state_r == W_IDLE)
    else $error("sequencer kept running after final word");
`endif

endmodule

`default_nettype wire
